FILE: sv/assert_macros.svh
// Assertion helpers used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check that is held off while reset is asserted.
`define PHV_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define PHV_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

FILE: sv/phv_pkg.sv
package phv_pkg;

    // Largest number of payload bytes scanned per packet.
    localparam int MAX_BYTES  = 64;
    // Width of the kept-packet counters.
    localparam int COUNT_BITS = 16;

    localparam int POS_W   = $clog2(MAX_BYTES);
    localparam int BYTE_W  = 8;
    localparam int LEN_W   = 32;
    localparam int RUN_W   = 10;
    localparam int LEN_SLACK = 8;
    localparam logic [RUN_W-1:0] RUN_SAT = '1;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    // Register indexes on the configuration port.
    typedef enum logic [2:0] {
        REG_BYTES_EXAMINED  = 3'd0,
        REG_ZERO_RUN_NEEDED = 3'd1,
        REG_LENGTH_CHECK_ON = 3'd2,
        REG_ZERO_CHECK_ON   = 3'd3,
        REG_CHECKS_NEEDED   = 3'd4,
        REG_PACKETS_NEEDED  = 3'd5
    } t_reg_idx;

    // Direction verdict codes.
    typedef enum logic [1:0] {
        VERDICT_FORWARD  = 2'd0,
        VERDICT_BACKWARD = 2'd1,
        VERDICT_TOO_FEW  = 2'd2
    } t_verdict;

    // Configuration register set.
    typedef struct packed {
        logic [6:0]  bytes_examined;
        logic [9:0]  zero_run_needed;
        logic        length_check_on;
        logic        zero_check_on;
        logic [1:0]  checks_needed;
        logic [15:0] packets_needed;
    } t_cfg;

    // One accepted input word.
    typedef struct packed {
        logic [BYTE_W-1:0] payload_byte;
        logic [LEN_W-1:0]  packet_length;
        logic              from_destination;
        logic              last_packet;
    } t_in_word;

    // One result word, packed so the last field is in the lowest bit.
    typedef struct packed {
        t_verdict flow_verdict;
        logic     packet_kept;
        logic     zero_run_found;
        logic     length_found;
    } t_out_word;

endpackage

FILE: sv/phv_regs.sv
module phv_regs (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            psel,
    input  logic            penable,
    input  logic            pwrite,
    input  logic [4:0]      paddr,
    input  logic [31:0]     pwdata,
    output logic [31:0]     prdata,
    output logic            pready,
    output phv_pkg::t_cfg   o_cfg
);

    phv_pkg::t_cfg    r_cfg;
    phv_pkg::t_reg_idx w_idx;
    logic             w_wr;

    assign w_idx  = phv_pkg::t_reg_idx'(paddr[4:2]);
    assign w_wr   = psel && penable && pwrite;
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    // Register writes; addresses past the last register are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.bytes_examined  <= 7'd64;
            r_cfg.zero_run_needed <= 10'd16;
            r_cfg.length_check_on <= 1'b1;
            r_cfg.zero_check_on   <= 1'b1;
            r_cfg.checks_needed   <= 2'd1;
            r_cfg.packets_needed  <= 16'd1;
        end else if (w_wr) begin
            case (w_idx)
                phv_pkg::REG_BYTES_EXAMINED:  r_cfg.bytes_examined  <= pwdata[6:0];
                phv_pkg::REG_ZERO_RUN_NEEDED: r_cfg.zero_run_needed <= pwdata[9:0];
                phv_pkg::REG_LENGTH_CHECK_ON: r_cfg.length_check_on <= pwdata[0];
                phv_pkg::REG_ZERO_CHECK_ON:   r_cfg.zero_check_on   <= pwdata[0];
                phv_pkg::REG_CHECKS_NEEDED:   r_cfg.checks_needed   <= pwdata[1:0];
                phv_pkg::REG_PACKETS_NEEDED:  r_cfg.packets_needed  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    // Read-back mux.
    always_comb begin
        prdata = '0;
        case (w_idx)
            phv_pkg::REG_BYTES_EXAMINED:  prdata = {25'd0, r_cfg.bytes_examined};
            phv_pkg::REG_ZERO_RUN_NEEDED: prdata = {22'd0, r_cfg.zero_run_needed};
            phv_pkg::REG_LENGTH_CHECK_ON: prdata = {31'd0, r_cfg.length_check_on};
            phv_pkg::REG_ZERO_CHECK_ON:   prdata = {31'd0, r_cfg.zero_check_on};
            phv_pkg::REG_CHECKS_NEEDED:   prdata = {30'd0, r_cfg.checks_needed};
            phv_pkg::REG_PACKETS_NEEDED:  prdata = {16'd0, r_cfg.packets_needed};
            default:                      prdata = '0;
        endcase
    end

endmodule

FILE: sv/phv_len_check.sv
module phv_len_check (
    input  logic [phv_pkg::BYTE_W-1:0] i_cur,
    input  logic [phv_pkg::BYTE_W-1:0] i_prev1,
    input  logic [phv_pkg::BYTE_W-1:0] i_prev2,
    input  logic [phv_pkg::BYTE_W-1:0] i_prev3,
    input  logic [phv_pkg::LEN_W-1:0]  i_len,
    input  logic [phv_pkg::POS_W-1:0]  i_pos,
    output logic                       o_hit
);

    logic [2:0]                  w_width;
    logic [phv_pkg::LEN_W-1:0]   w_be;
    logic [phv_pkg::LEN_W-1:0]   w_le;
    logic [phv_pkg::LEN_W:0]     w_dbe;
    logic [phv_pkg::LEN_W:0]     w_dle;
    logic                        w_enough;

    // Window width is the byte count of the packet length.
    always_comb begin
        if (i_len <= 32'h0000_00FF)      w_width = 3'd1;
        else if (i_len <= 32'h0000_FFFF) w_width = 3'd2;
        else if (i_len <= 32'h00FF_FFFF) w_width = 3'd3;
        else                             w_width = 3'd4;
    end

    // Big and little endian readings of the window ending at the current byte.
    always_comb begin
        case (w_width)
            3'd1: begin
                w_be = {24'd0, i_cur};
                w_le = {24'd0, i_cur};
            end
            3'd2: begin
                w_be = {16'd0, i_prev1, i_cur};
                w_le = {16'd0, i_cur, i_prev1};
            end
            3'd3: begin
                w_be = {8'd0, i_prev2, i_prev1, i_cur};
                w_le = {8'd0, i_cur, i_prev1, i_prev2};
            end
            default: begin
                w_be = {i_prev3, i_prev2, i_prev1, i_cur};
                w_le = {i_cur, i_prev1, i_prev2, i_prev3};
            end
        endcase
    end

    // The window must lie fully inside the bytes seen so far.
    assign w_enough = ({1'b0, i_pos} + (phv_pkg::POS_W+1)'(1)) >=
                      (phv_pkg::POS_W+1)'(w_width);

    // |v - len| <= slack, done as one offset subtract and an unsigned compare.
    assign w_dbe = {1'b0, w_be} - {1'b0, i_len} + (phv_pkg::LEN_W+1)'(phv_pkg::LEN_SLACK);
    assign w_dle = {1'b0, w_le} - {1'b0, i_len} + (phv_pkg::LEN_W+1)'(phv_pkg::LEN_SLACK);

    assign o_hit = w_enough &&
                   ((w_dbe <= (phv_pkg::LEN_W+1)'(2*phv_pkg::LEN_SLACK)) ||
                    (w_dle <= (phv_pkg::LEN_W+1)'(2*phv_pkg::LEN_SLACK)));

endmodule

FILE: sv/payload_heuristic_vote_unit.sv
// Words pass the input register, and results the output register, on the way to m_axis.
// Throughput: one payload byte per cycle unless a packet's last byte meets a stalled
// result slot; the two registers let a byte in while a packet result waits on m_axis.
// One result word leaves per packet, on its last examined byte.
// Reset (synchronous, active low) restores register defaults, clears the packet state
// and both kept counters, and empties both pipeline registers.
`include "assert_macros.svh"

module payload_heuristic_vote_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input stream.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // [7:0] payload_byte, [39:8] packet_length
    input  logic [0:0]  s_axis_tuser,   // [0] from_destination
    input  logic        s_axis_tlast,   // last_packet
    // Result stream.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [0] length_found, [1] zero_run_found,
                                        // [2] packet_kept, [4:3] flow_verdict, [7:5] zero
    output logic        m_axis_tlast,   // flow_done
    // Configuration port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int PW = phv_pkg::POS_W;
    localparam int CW = phv_pkg::COUNT_BITS;

    phv_pkg::t_cfg      w_cfg;

    // Input register.
    logic               r_in_valid;
    phv_pkg::t_in_word  r_in;

    // Packet and flow state.
    logic [PW-1:0]                 r_pos;
    logic [phv_pkg::BYTE_W-1:0]    r_prev [3];
    logic [phv_pkg::RUN_W-1:0]     r_zrun;
    logic                          r_len_seen;
    logic                          r_zero_seen;
    logic [CW-1:0]                 r_fwd_cnt;
    logic [CW-1:0]                 r_bwd_cnt;

    // Output register.
    logic               r_out_valid;
    phv_pkg::t_out_word r_out;
    logic               r_out_done;

    logic               w_len_hit;
    logic [PW:0]        w_nbytes;
    logic               w_pkt_end;
    logic               w_proc;
    logic               w_emit;
    logic [phv_pkg::RUN_W-1:0] n_zrun;
    logic               n_zero_seen;
    logic               n_len_seen;
    logic [1:0]         w_votes;
    logic               w_kept;
    logic [CW-1:0]      n_fwd_cnt;
    logic [CW-1:0]      n_bwd_cnt;
    phv_pkg::t_verdict  w_verdict;

    phv_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    phv_len_check u_len (
        .i_cur   (r_in.payload_byte),
        .i_prev1 (r_prev[0]),
        .i_prev2 (r_prev[1]),
        .i_prev3 (r_prev[2]),
        .i_len   (r_in.packet_length),
        .i_pos   (r_pos),
        .o_hit   (w_len_hit)
    );

    // Effective bytes per packet: zero acts as one, large values clamp.
    always_comb begin
        if (w_cfg.bytes_examined == 7'd0) begin
            w_nbytes = (PW+1)'(1);
        end else if (32'(w_cfg.bytes_examined) > 32'(phv_pkg::MAX_BYTES)) begin
            w_nbytes = (PW+1)'(phv_pkg::MAX_BYTES);
        end else begin
            w_nbytes = (PW+1)'(w_cfg.bytes_examined);
        end
    end

    assign w_pkt_end = ({1'b0, r_pos} + (PW+1)'(1)) >= w_nbytes;

    // A word moves on unless it ends a packet and the result slot stays full.
    assign w_proc = r_in_valid && (!w_pkt_end || !r_out_valid || m_axis_tready);
    assign w_emit = w_proc && w_pkt_end;
    assign s_axis_tready = !r_in_valid || w_proc;

    // Zero-bit run, scanned LSB first across the byte.
    always_comb begin
        n_zrun      = r_zrun;
        n_zero_seen = r_zero_seen;
        for (int i = 0; i < phv_pkg::BYTE_W; i++) begin
            if (!r_in.payload_byte[i]) begin
                if (n_zrun < phv_pkg::RUN_SAT) begin
                    n_zrun = n_zrun + phv_pkg::RUN_W'(1);
                end
                if (n_zrun >= w_cfg.zero_run_needed) begin
                    n_zero_seen = 1'b1;
                end
            end else begin
                n_zrun = '0;
            end
        end
    end

    assign n_len_seen = r_len_seen || w_len_hit;

    // Votes, kept decision, saturating per-direction counts and flow verdict.
    always_comb begin
        w_votes = 2'(w_cfg.length_check_on && n_len_seen) +
                  2'(w_cfg.zero_check_on && n_zero_seen);
        w_kept  = w_votes >= w_cfg.checks_needed;
        n_fwd_cnt = r_fwd_cnt;
        n_bwd_cnt = r_bwd_cnt;
        if (w_kept) begin
            if (r_in.from_destination) begin
                if (r_bwd_cnt != phv_pkg::COUNT_MAX) n_bwd_cnt = r_bwd_cnt + CW'(1);
            end else begin
                if (r_fwd_cnt != phv_pkg::COUNT_MAX) n_fwd_cnt = r_fwd_cnt + CW'(1);
            end
        end
        w_verdict = phv_pkg::VERDICT_FORWARD;
        if (r_in.last_packet) begin
            if (32'(n_fwd_cnt) >= 32'(w_cfg.packets_needed)) begin
                w_verdict = phv_pkg::VERDICT_FORWARD;
            end else if (32'(n_bwd_cnt) >= 32'(w_cfg.packets_needed)) begin
                w_verdict = phv_pkg::VERDICT_BACKWARD;
            end else begin
                w_verdict = phv_pkg::VERDICT_TOO_FEW;
            end
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in.payload_byte     <= s_axis_tdata[7:0];
            r_in.packet_length    <= s_axis_tdata[39:8];
            r_in.from_destination <= s_axis_tuser[0];
            r_in.last_packet      <= s_axis_tlast;
        end
    end

    // Packet state and kept counters.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_prev[0]   <= '0;
            r_prev[1]   <= '0;
            r_prev[2]   <= '0;
            r_zrun      <= '0;
            r_len_seen  <= 1'b0;
            r_zero_seen <= 1'b0;
            r_fwd_cnt   <= '0;
            r_bwd_cnt   <= '0;
        end else if (w_proc) begin
            if (w_pkt_end) begin
                r_pos       <= '0;
                r_prev[0]   <= '0;
                r_prev[1]   <= '0;
                r_prev[2]   <= '0;
                r_zrun      <= '0;
                r_len_seen  <= 1'b0;
                r_zero_seen <= 1'b0;
                if (r_in.last_packet) begin
                    r_fwd_cnt <= '0;
                    r_bwd_cnt <= '0;
                end else begin
                    r_fwd_cnt <= n_fwd_cnt;
                    r_bwd_cnt <= n_bwd_cnt;
                end
            end else begin
                r_pos       <= r_pos + PW'(1);
                r_prev[0]   <= r_in.payload_byte;
                r_prev[1]   <= r_prev[0];
                r_prev[2]   <= r_prev[1];
                r_zrun      <= n_zrun;
                r_len_seen  <= n_len_seen;
                r_zero_seen <= n_zero_seen;
            end
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out.length_found   <= n_len_seen;
            r_out.zero_run_found <= n_zero_seen;
            r_out.packet_kept    <= w_kept;
            r_out.flow_verdict   <= w_verdict;
            r_out_done           <= r_in.last_packet;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'd0, r_out};
    assign m_axis_tlast  = r_out_done;

    `PHV_ASSERT(a_flow_end_clears, w_emit && r_in.last_packet |=> r_fwd_cnt == '0 && r_bwd_cnt == '0, "kept counters not cleared at end of flow")
    `PHV_ASSERT(a_pkt_end_rewinds, w_emit |=> r_pos == '0 && !r_len_seen && !r_zero_seen, "packet state not cleared after last byte")
    `PHV_ASSERT(a_verdict_idle, r_out_valid && !r_out_done |-> r_out.flow_verdict == phv_pkg::VERDICT_FORWARD, "verdict set without flow end")
    `PHV_ASSERT(a_pos_range, 32'(r_pos) < 32'(phv_pkg::MAX_BYTES), "byte position out of range")

endmodule
